### src/lru_key_cache_lookup_defines.svh
// Assertion macros used by the cache lookup back end.
`ifndef LRU_KEY_CACHE_LOOKUP_DEFINES_SVH
`define LRU_KEY_CACHE_LOOKUP_DEFINES_SVH
`ifndef SYNTHESIS
`define LKC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LKC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LKC_ASSERT(lbl, clk, rst_n, prop, msg)
`define LKC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/lkc_pkg.sv
// Shared constants and types of the key cache lookup.
package lkc_pkg;

  localparam int unsigned KeyW    = 64;
  localparam int unsigned WayOutW = 5;
  localparam int unsigned CostW   = 20;
  localparam int unsigned CfgW    = 6;

  localparam int unsigned DefWays     = 32;
  localparam int unsigned DefKeyChars = 8;

  localparam logic [CfgW-1:0]  WaysReset = CfgW'(32);
  localparam logic [CostW-1:0] HitCost   = CostW'(1);
  localparam logic [CostW-1:0] MissCost  = CostW'(5);
  localparam logic [CostW-1:0] CostMax   = '1;

  typedef enum logic {
    LKC_LOOKUP,
    LKC_UPDATE
  } lkc_state_e;

  // One folded key moving through the queue.
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
  } lkc_item_t;

endpackage

### src/lkc_if.sv
// Request and response channel interfaces.
interface lkc_req_if;
  import lkc_pkg::*;
  logic            valid;
  logic            ready;
  logic [KeyW-1:0] city_key;
  modport source (output valid, output city_key, input ready);
  modport sink (input valid, input city_key, output ready);
endinterface

interface lkc_rsp_if;
  import lkc_pkg::*;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [WayOutW-1:0] way;
  logic [CostW-1:0]   total_cost;
  modport source (output valid, output hit, output way, output total_cost, input ready);
  modport sink (input valid, input hit, input way, input total_cost, output ready);
endinterface

### src/lru_key_cache_lookup.sv
// Top level of the fully associative LRU key cache lookup.
//
//  channel   dir  handshake        payload
//  req_i     in   valid/ready      city_key[63:0]
//  rsp_o     out  valid/ready      hit, way[4:0], total_cost[19:0]
//  cfg       in   cfg_we_i         cfg_wdata_i[5:0] (ways in use)
//
// In the back end each key passes LOOKUP (parallel tag compare and LRU victim tree)
// and then UPDATE (rank update, fill and cost); a new key waits until UPDATE is done.
// A two-entry queue decouples the front end; a full queue drops req_i.ready.
// A held result stalls the back end in its update cycle until rsp_o.ready.
// Reset clears all entries to invalid, ranks to entry order, cost to zero, ways to 32.
module lru_key_cache_lookup #(
  parameter int unsigned WAYS      = lkc_pkg::DefWays,
  parameter int unsigned KEY_CHARS = lkc_pkg::DefKeyChars
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [lkc_pkg::CfgW-1:0] cfg_wdata_i,
  lkc_req_if.sink                  req_i,
  lkc_rsp_if.source                rsp_o
);
  import lkc_pkg::*;

  logic [CfgW-1:0] ways_q;
  lkc_item_t       push, head;
  logic            full, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_q <= WaysReset;
    end else if (cfg_we_i) begin
      ways_q <= cfg_wdata_i;
    end
  end

  lkc_front #(
    .KEY_CHARS(KEY_CHARS)
  ) u_front (
    .req_i (req_i),
    .full_i(full),
    .push_o(push)
  );

  lkc_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .full_o(full),
    .head_o(head),
    .pop_i (pop)
  );

  lkc_back #(
    .WAYS(WAYS)
  ) u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ways_i(ways_q),
    .head_i(head),
    .pop_o (pop),
    .rsp_o (rsp_o)
  );

endmodule

### src/lkc_front.sv
// Front end: accepts keys, folds them to lower case and pushes them to the queue.
module lkc_front #(
  parameter int unsigned KEY_CHARS = lkc_pkg::DefKeyChars
) (
  lkc_req_if.sink              req_i,
  input  logic                 full_i,
  output lkc_pkg::lkc_item_t   push_o
);
  import lkc_pkg::*;

  localparam int unsigned NumBytes = KeyW / 8;
  localparam logic [7:0]  ChUpperA = 8'h41;
  localparam logic [7:0]  ChUpperZ = 8'h5A;
  localparam logic [7:0]  CaseBit  = 8'h20;

  logic [KeyW-1:0] folded;

  always_comb begin
    logic [7:0] ch;
    folded = '0;
    for (int b = 0; b < NumBytes; b++) begin
      ch = req_i.city_key[8*b +: 8];
      if (b >= KEY_CHARS) begin
        ch = '0;
      end else if (ch >= ChUpperA && ch <= ChUpperZ) begin
        ch = ch | CaseBit;
      end
      folded[8*b +: 8] = ch;
    end
  end

  assign req_i.ready  = !full_i;
  assign push_o.valid = req_i.valid && !full_i;
  assign push_o.key   = folded;

endmodule

### src/lkc_fifo.sv
// Two-entry queue of folded keys between front and back end.
module lkc_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lkc_pkg::lkc_item_t push_i,
  output logic               full_o,
  output lkc_pkg::lkc_item_t head_o,
  input  logic               pop_i
);
  import lkc_pkg::*;

  logic [KeyW-1:0] slot_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            do_push, do_pop;

  assign full_o       = count_q == 2'd2;
  assign head_o.valid = count_q != 2'd0;
  assign head_o.key   = slot_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_i.key;
    end
  end

endmodule

### src/lkc_back.sv
// Back end: tag compare, LRU replacement, rank update, cost and result register.
`include "lru_key_cache_lookup_defines.svh"
module lkc_back #(
  parameter int unsigned WAYS = lkc_pkg::DefWays
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [lkc_pkg::CfgW-1:0] ways_i,
  input  lkc_pkg::lkc_item_t       head_i,
  output logic                     pop_o,
  lkc_rsp_if.source                rsp_o
);
  import lkc_pkg::*;

  localparam int unsigned IdxW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned Leaves = 1 << IdxW;

  lkc_state_e state_q, state_d;

  // entry state
  logic [KeyW-1:0] key_q   [WAYS];
  logic [WAYS-1:0] valid_q;
  logic [IdxW-1:0] rank_q  [WAYS];
  logic [IdxW-1:0] rank_d  [WAYS];

  // lookup stage registers
  logic [KeyW-1:0] cur_key_q;
  logic [WAYS-1:0] match_q, match_d;
  logic [WAYS-1:0] empty_q, empty_d;
  logic [IdxW-1:0] victim_q;
  logic            used_nz_q;

  // result register
  logic             out_vld_q;
  logic             res_hit_q;
  logic [IdxW-1:0]  res_way_q;
  logic [CostW-1:0] cost_q, cost_d;

  logic            capture, upd_go;
  logic [WAYS-1:0] in_use;

  // victim tree, heap order, leaves at Leaves..2*Leaves-1
  logic            tr_vld  [2*Leaves];
  logic [IdxW-1:0] tr_rank [2*Leaves];
  logic [IdxW-1:0] tr_idx  [2*Leaves];

  logic            any_hit, any_empty;
  logic [IdxW-1:0] hit_way, empty_way, sel_way, touch_rank;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      in_use[i]  = 7'(i) < {1'b0, ways_i};
      match_d[i] = valid_q[i] && in_use[i] && (key_q[i] == head_i.key);
      empty_d[i] = in_use[i] && !valid_q[i];
    end
  end

  always_comb begin
    tr_vld[0]  = 1'b0;
    tr_rank[0] = '0;
    tr_idx[0]  = '0;
    for (int i = 0; i < Leaves; i++) begin
      tr_idx[Leaves+i] = IdxW'(i);
      if (i < WAYS) begin
        tr_vld[Leaves+i]  = in_use[i];
        tr_rank[Leaves+i] = rank_q[i];
      end else begin
        tr_vld[Leaves+i]  = 1'b0;
        tr_rank[Leaves+i] = '0;
      end
    end
    for (int k = Leaves - 1; k >= 1; k--) begin
      if (tr_vld[2*k+1] && (!tr_vld[2*k] || tr_rank[2*k+1] > tr_rank[2*k])) begin
        tr_vld[k]  = 1'b1;
        tr_rank[k] = tr_rank[2*k+1];
        tr_idx[k]  = tr_idx[2*k+1];
      end else begin
        tr_vld[k]  = tr_vld[2*k];
        tr_rank[k] = tr_rank[2*k];
        tr_idx[k]  = tr_idx[2*k];
      end
    end
  end

  // lowest index wins for both hit and empty slot
  always_comb begin
    hit_way   = '0;
    empty_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match_q[i]) hit_way = IdxW'(i);
      if (empty_q[i]) empty_way = IdxW'(i);
    end
    any_hit   = |match_q;
    any_empty = |empty_q;
    if (any_hit) begin
      sel_way = hit_way;
    end else if (any_empty) begin
      sel_way = empty_way;
    end else begin
      sel_way = victim_q;
    end
    touch_rank = rank_q[sel_way];
  end

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      rank_d[i] = rank_q[i];
      if (upd_go && used_nz_q) begin
        if (IdxW'(i) == sel_way) begin
          rank_d[i] = '0;
        end else if (rank_q[i] < touch_rank) begin
          rank_d[i] = rank_q[i] + 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic [CostW:0]   sum;
    logic [CostW-1:0] inc;
    inc    = (used_nz_q && any_hit) ? HitCost : MissCost;
    sum    = {1'b0, cost_q} + {1'b0, inc};
    cost_d = sum[CostW] ? CostMax : sum[CostW-1:0];
  end

  always_comb begin
    state_d = state_q;
    capture = 1'b0;
    upd_go  = 1'b0;
    unique case (state_q)
      LKC_LOOKUP: begin
        if (head_i.valid) begin
          capture = 1'b1;
          state_d = LKC_UPDATE;
        end
      end
      LKC_UPDATE: begin
        if (!out_vld_q || rsp_o.ready) begin
          upd_go  = 1'b1;
          state_d = LKC_LOOKUP;
        end
      end
      default: state_d = LKC_LOOKUP;
    endcase
  end

  assign pop_o = capture;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= LKC_LOOKUP;
      valid_q   <= '0;
      out_vld_q <= 1'b0;
      cost_q    <= '0;
      for (int i = 0; i < WAYS; i++) begin
        rank_q[i] <= IdxW'(i);
      end
    end else begin
      state_q <= state_d;
      rank_q  <= rank_d;
      if (upd_go) begin
        out_vld_q <= 1'b1;
        cost_q    <= cost_d;
        if (used_nz_q && !any_hit) begin
          valid_q[sel_way] <= 1'b1;
        end
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      cur_key_q <= head_i.key;
      match_q   <= match_d;
      empty_q   <= empty_d;
      victim_q  <= tr_idx[1];
      used_nz_q <= ways_i != '0;
    end
    if (upd_go) begin
      res_hit_q <= used_nz_q && any_hit;
      res_way_q <= used_nz_q ? sel_way : '0;
      if (used_nz_q && !any_hit) begin
        key_q[sel_way] <= cur_key_q;
      end
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.hit        = res_hit_q;
  assign rsp_o.way        = WayOutW'(res_way_q);
  assign rsp_o.total_cost = cost_q;

  `LKC_ASSERT(a_cost_mono, clk_i, rst_ni, cost_q >= $past(cost_q), "cost decreased")
  `LKC_ASSERT(a_hit_valid, clk_i, rst_ni, out_vld_q && res_hit_q |-> valid_q[res_way_q], "hit on invalid entry")
  `LKC_ASSERT_NXT(a_mru, clk_i, rst_ni, upd_go && used_nz_q, rank_q[res_way_q] == '0, "accessed entry not most recent")

endmodule

### sim/lru_key_cache_lookup_tb.sv
// Self-checking testbench of the LRU key cache lookup: directed table and random phases.
module lru_key_cache_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lkc_pkg::*;

  typedef enum logic {
    ROW_KEY,
    ROW_WAYS
  } row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [KeyW-1:0]    value;
    bit                 typed;
    logic               hit;
    logic [WayOutW-1:0] way;
    logic [CostW-1:0]   cost;
  } dir_row_t;

  typedef struct {
    logic               hit;
    logic [WayOutW-1:0] way;
    logic [CostW-1:0]   total_cost;
  } lookup_res_t;

  localparam int NumDirRows = 27;
  localparam int PoolSize   = 48;
  localparam int LongHold   = 200;
  localparam int MaxShown   = 10;

  // Directed rows; cost and way are typed in only where they follow from the row order.
  dir_row_t dir_rows [NumDirRows] = '{
    '{ROW_KEY,  64'h0,                  1'b1, 1'b0, 5'd0, 20'd5},
    '{ROW_KEY,  64'h0,                  1'b1, 1'b1, 5'd0, 20'd6},
    '{ROW_KEY,  64'h0000_0053_4952_4150, 1'b1, 1'b0, 5'd1, 20'd11},  // PARIS
    '{ROW_KEY,  64'h0000_0073_6972_6170, 1'b1, 1'b1, 5'd1, 20'd12},  // paris
    '{ROW_KEY,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 5'd2, 20'd17},
    '{ROW_KEY,  64'h5A5A_5A5A_5A5A_5A5A, 1'b1, 1'b0, 5'd3, 20'd22},
    '{ROW_KEY,  64'h7A7A_7A7A_7A7A_7A7A, 1'b1, 1'b1, 5'd3, 20'd23},
    '{ROW_KEY,  64'h4040_4040_4040_4040, 1'b1, 1'b0, 5'd4, 20'd28},
    '{ROW_KEY,  64'h5B5B_5B5B_5B5B_5B5B, 1'b1, 1'b0, 5'd5, 20'd33},
    '{ROW_KEY,  64'h4141_4141_4141_4141, 1'b1, 1'b0, 5'd6, 20'd38},
    '{ROW_KEY,  64'h6161_6161_6161_6161, 1'b1, 1'b1, 5'd6, 20'd39},
    '{ROW_KEY,  64'h6060_6060_6060_6060, 1'b1, 1'b0, 5'd7, 20'd44},
    '{ROW_KEY,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 5'd2, 20'd45},
    '{ROW_WAYS, 64'd0,                  1'b0, 1'b0, 5'd0, 20'd0},
    '{ROW_KEY,  64'h0000_0053_4952_4150, 1'b1, 1'b0, 5'd0, 20'd50},
    '{ROW_KEY,  64'h8000_0000_0000_0000, 1'b1, 1'b0, 5'd0, 20'd55},
    '{ROW_WAYS, 64'd1,                  1'b0, 1'b0, 5'd0, 20'd0},
    '{ROW_KEY,  64'h0000_0073_6972_6170, 1'b1, 1'b0, 5'd0, 20'd60},
    '{ROW_WAYS, 64'd32,                 1'b0, 1'b0, 5'd0, 20'd0},
    // entries 0 and 1 now both hold paris: the lower index wins
    '{ROW_KEY,  64'h0000_0073_6972_6150, 1'b1, 1'b1, 5'd0, 20'd61},
    '{ROW_KEY,  64'h0,                  1'b1, 1'b0, 5'd8, 20'd66},
    '{ROW_WAYS, 64'd63,                 1'b0, 1'b0, 5'd0, 20'd0},
    '{ROW_KEY,  64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 5'd0, 20'd0},
    '{ROW_WAYS, 64'd2,                  1'b0, 1'b0, 5'd0, 20'd0},
    '{ROW_KEY,  64'h1,                  1'b0, 1'b0, 5'd0, 20'd0},
    '{ROW_KEY,  64'h2,                  1'b0, 1'b0, 5'd0, 20'd0},
    '{ROW_KEY,  64'h1,                  1'b0, 1'b0, 5'd0, 20'd0}
  };

  localparam logic [7:0] EdgeBytes [10] = '{8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60,
                                            8'h61, 8'h7A, 8'h7B, 8'hC1, 8'hFF};

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;

  lkc_req_if req_if ();
  lkc_rsp_if rsp_if ();

  lru_key_cache_lookup i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // cache image
  logic [KeyW-1:0]    mdl_key   [DefWays];
  bit                 mdl_valid [DefWays];
  logic [4:0]         mdl_rank  [DefWays];
  logic [CostW-1:0]   mdl_cost;
  logic [CfgW-1:0]    mdl_ways;

  lookup_res_t     pending_results [$];
  logic [KeyW-1:0] word_pool [PoolSize];

  bit          typed_pending;
  lookup_res_t typed_result;
  bit          steady;
  bit          hold_req;
  int          bad_results;
  int          shown;
  int          n_lookups;
  int          n_hits;
  int          n_misses;
  int          n_ways_writes;
  int          n_long_holds;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #30_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic void cache_clear();
    for (int i = 0; i < DefWays; i++) begin
      mdl_key[i]   = '0;
      mdl_valid[i] = 1'b0;
      mdl_rank[i]  = 5'(i);
    end
    mdl_cost = '0;
    mdl_ways = WaysReset;
  endfunction

  function automatic lookup_res_t cache_access(input logic [KeyW-1:0] raw);
    logic [KeyW-1:0] key;
    logic [7:0]      ch;
    int              used;
    int              way;
    bit              hit;
    bit              found;
    logic [4:0]      worst;
    logic [4:0]      old_rank;
    logic [CostW:0]  sum;
    lookup_res_t     res;
    key = '0;
    for (int b = 0; b < 8; b++) begin
      ch = (b < DefKeyChars) ? raw[8*b +: 8] : 8'h00;
      if (ch >= 8'h41 && ch <= 8'h5A) ch = ch + 8'h20;
      key[8*b +: 8] = ch;
    end
    used  = (mdl_ways > DefWays) ? DefWays : int'(mdl_ways);
    hit   = 1'b0;
    found = 1'b0;
    way   = 0;
    if (used == 0) begin
      sum = mdl_cost + MissCost;
    end else begin
      for (int i = 0; i < used; i++) begin
        if (!hit && mdl_valid[i] && mdl_key[i] == key) begin
          hit = 1'b1;
          way = i;
        end
      end
      if (hit) begin
        sum = mdl_cost + HitCost;
      end else begin
        for (int i = 0; i < used; i++) begin
          if (!found && !mdl_valid[i]) begin
            found = 1'b1;
            way   = i;
          end
        end
        if (!found) begin
          worst = '0;
          for (int i = 0; i < used; i++) begin
            if (mdl_rank[i] > worst) begin
              worst = mdl_rank[i];
              way   = i;
            end
          end
        end
        mdl_key[way]   = key;
        mdl_valid[way] = 1'b1;
        sum = mdl_cost + MissCost;
      end
      old_rank = mdl_rank[way];
      for (int i = 0; i < DefWays; i++) begin
        if (mdl_rank[i] < old_rank) mdl_rank[i] = mdl_rank[i] + 5'd1;
      end
      mdl_rank[way] = '0;
    end
    mdl_cost       = (sum > CostMax) ? CostMax : sum[CostW-1:0];
    res.hit        = hit;
    res.way        = WayOutW'(way);
    res.total_cost = mdl_cost;
    return res;
  endfunction

  // Mostly pool words with random case, some raw noise, some keys built from letter-edge bytes.
  function automatic logic [KeyW-1:0] make_key(input int span);
    logic [KeyW-1:0] k;
    logic [7:0]      ch;
    int              r;
    int              len;
    int              idx;
    k = '0;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      k = word_pool[$urandom_range(0, span - 1)];
      for (int b = 0; b < 8; b++) begin
        ch = k[8*b +: 8];
        if (ch >= 8'h61 && ch <= 8'h7A && $urandom_range(0, 1) == 1) k[8*b +: 8] = ch - 8'h20;
      end
    end else if (r < 88) begin
      k = {$urandom, $urandom};
    end else begin
      len = $urandom_range(0, 8);
      for (int b = 0; b < len; b++) begin
        idx = $urandom_range(0, 10);
        k[8*b +: 8] = (idx == 10) ? 8'($urandom) : EdgeBytes[idx];
      end
    end
    return k;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Entered at a falling edge; returns at the falling edge after the item was taken.
  task automatic send_key(input logic [KeyW-1:0] k, input bit typed, input lookup_res_t want);
    typed_pending = typed;
    typed_result  = want;
    req_if.valid    <= 1'b1;
    req_if.city_key <= k;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      req_if.valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic write_ways(input logic [CfgW-1:0] v);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    mdl_ways = v;
    n_ways_writes++;
  endtask

  // Output side: random ready with a long hold-off on request.
  initial begin : rsp_ready_gen
    int stall_left;
    int r;
    bit rdy;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LongHold;
        n_long_holds++;
      end
      if (stall_left > 0) begin
        rdy = 1'b0;
        stall_left--;
      end else if (steady) begin
        rdy = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          rdy = 1'b1;
        end else begin
          rdy = 1'b0;
          stall_left = (r < 92) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        end
      end
      rsp_if.ready <= rdy;
    end
  end

  // Results are checked before the request of the same edge is predicted.
  always @(posedge clk_i) begin : monitor
    lookup_res_t want;
    lookup_res_t got;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.hit        = rsp_if.hit;
        got.way        = rsp_if.way;
        got.total_cost = rsp_if.total_cost;
        if (got.hit === 1'b1) n_hits++;
        else n_misses++;
        if (pending_results.size() == 0) begin
          bad_results++;
          if (shown < MaxShown) begin
            shown++;
            $display("%0t: result with nothing pending: hit=%0b way=%0d cost=%0d",
                     $realtime, got.hit, got.way, got.total_cost);
          end
        end else begin
          want = pending_results.pop_front();
          if (got.hit !== want.hit || got.way !== want.way ||
              got.total_cost !== want.total_cost) begin
            bad_results++;
            if (shown < MaxShown) begin
              shown++;
              $display("%0t: mismatch exp hit=%0b way=%0d cost=%0d got hit=%0b way=%0d cost=%0d",
                       $realtime, want.hit, want.way, want.total_cost,
                       got.hit, got.way, got.total_cost);
            end
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        want = cache_access(req_if.city_key);
        if (typed_pending) begin
          want          = typed_result;
          typed_pending = 1'b0;
        end
        pending_results.push_back(want);
        n_lookups++;
      end
    end
  end

  initial begin : stimulus
    logic [CfgW-1:0] ways_plan [11];
    lookup_res_t     want;
    lookup_res_t     none;
    int              len;
    int              n_items;
    int              span;
    int              waited;
    ways_plan = '{6'd32, 6'd5, 6'd1, 6'd0, 6'd63, 6'd2, 6'd17, 6'd31, 6'd33, 6'd12, 6'd32};
    none = '{1'b0, '0, '0};
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    req_if.valid    <= 1'b0;
    req_if.city_key <= '0;
    typed_pending = 1'b0;
    steady        = 1'b0;
    hold_req      = 1'b0;
    cache_clear();
    word_pool[0] = '0;
    for (int w = 1; w < PoolSize; w++) begin
      word_pool[w] = '0;
      len = $urandom_range(1, 8);
      for (int b = 0; b < len; b++) word_pool[w][8*b +: 8] = 8'h61 + 8'($urandom_range(0, 25));
    end
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WAYS) begin
        write_ways(dir_rows[i].value[CfgW-1:0]);
      end else begin
        want = '{dir_rows[i].hit, dir_rows[i].way, dir_rows[i].cost};
        send_key(dir_rows[i].value, dir_rows[i].typed, want);
        pause(pick_gap());
      end
    end

    foreach (ways_plan[p]) begin
      write_ways(ways_plan[p]);
      steady = (p == 1 || p == 6);
      // fill the queue against a stalled output while input keeps offering
      if (p == 1) hold_req = 1'b1;
      span    = (ways_plan[p] > DefWays) ? DefWays + 6 : int'(ways_plan[p]) + 6;
      span    = (span > PoolSize) ? PoolSize : span;
      n_items = (ways_plan[p] == 0) ? 60 : 183;
      for (int n = 0; n < n_items; n++) begin
        send_key(make_key(span), 1'b0, none);
        pause(pick_gap());
      end
    end

    write_ways(WaysReset);
    steady = 1'b0;
    for (int n = 0; n < 40; n++) begin
      send_key(make_key(12), 1'b0, none);
      pause(pick_gap());
    end
    req_if.valid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 5000) begin
      @(negedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $display("%0d results never arrived", pending_results.size());
      bad_results += pending_results.size();
    end
    repeat (20) @(negedge clk_i);

    $display("checked %0d lookups (%0d hits, %0d misses) across %0d ways settings",
             n_lookups, n_hits, n_misses, n_ways_writes);
    $display("cost ended at %0d, long output hold-offs: %0d, failures: %0d",
             mdl_cost, n_long_holds, bad_results);
    if (bad_results == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
